// File: rtl/lru_page_frame_replacer_defines.svh
// ----------------------------------------------------------------------------
// LRU page frame replacer assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_FRAME_REPLACER_DEFINES_SVH
`define LRU_PAGE_FRAME_REPLACER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page frame replacer package
// Field widths, limits and the result beat type shared by the block's files.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfr_pkg;

    localparam int PAGE_IN_W   = 16;
    localparam int FRAME_IDX_W = 4;
    localparam int TALLY_W     = 16;

    typedef logic [PAGE_IN_W-1:0]   t_page;
    typedef logic [FRAME_IDX_W-1:0] t_frame_idx;
    typedef logic [TALLY_W-1:0]     t_tally;

    localparam t_tally TALLY_MAX = '1;

    typedef struct packed {
        logic       hit;
        t_frame_idx frame_index;
        logic       evicted_valid;
        t_page      evicted_page;
        t_tally     faults_so_far;
    } t_rsp_beat;

endpackage

`default_nettype wire

// File: rtl/lpfr_if.sv
// ----------------------------------------------------------------------------
// LRU page frame replacer channels
// Valid/ready channels for page references and for lookup results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfr_req_if import lpfr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_page page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lpfr_rsp_if import lpfr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       hit;
    t_frame_idx frame_index;
    logic       evicted_valid;
    t_page      evicted_page;
    t_tally     faults_so_far;

    modport source (
        output valid, output hit, output frame_index, output evicted_valid,
        output evicted_page, output faults_so_far, input ready
    );
    modport sink (
        input valid, input hit, input frame_index, input evicted_valid,
        input evicted_page, input faults_so_far, output ready
    );
endinterface

`default_nettype wire

// File: rtl/lru_page_frame_replacer.sv
// ----------------------------------------------------------------------------
// LRU page frame replacer
// Fully associative set of page frames with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one page reference per beat; o_rsp returns exactly one
//   result beat per reference, in order: hit or fault, the frame that now
//   holds the page, the evicted page if one was replaced, and the saturating
//   fault tally after this reference.
//   A reference is first captured in an input register. Once the result
//   register is free, the block compares it against every frame, picks the
//   frame (hit, first empty frame, or least recently used), updates the
//   frame contents, valid bits, recency ranks and tally, and loads the
//   result register, which drives o_rsp. Throughput is one reference per
//   cycle while the receiver does not stall; the rate is set by the
//   parallel tag compare and rank update against the frame registers.
//   When the receiver stalls, the result register holds its beat and the
//   input register keeps one more reference; i_req.ready then drops until
//   o_rsp.ready returns.
//   Synchronous reset empties all frames, clears the ranks and the tally,
//   and drops both pipeline registers. Frame page contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_frame_replacer import lpfr_pkg::*; #(
    parameter int FRAMES    = 4,
    parameter int PAGE_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lpfr_req_if.sink    i_req,
    lpfr_rsp_if.source  o_rsp
);

    // Frame index and recency rank share one width; ranks run 0..FRAMES-1.
    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(FRAMES - 1);

    typedef logic [PAGE_BITS-1:0] t_frame_page;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [RANK_W-1:0]    t_rank;

    // Pipeline registers.
    logic        r_in_valid;
    t_frame_page r_in_page;
    logic        r_out_valid;
    t_rsp_beat   r_out;

    // Frame state.
    t_frame_page       r_frame_page [FRAMES];
    logic [FRAMES-1:0] r_frame_valid;
    t_rank             r_rank [FRAMES];
    t_tally            r_tally;

    // Next values and lookup signals.
    t_rank             n_rank [FRAMES];
    logic [FRAMES-1:0] n_frame_valid;
    t_tally            n_tally;
    t_rsp_beat         n_out;

    logic              w_out_free;
    logic              w_advance;
    logic [31:0]       w_page_wide;
    logic [31:0]       w_evict_wide;
    logic [FRAMES-1:0] w_match;
    logic [FRAMES-1:0] w_lru_vec;
    logic              w_hit;
    logic              w_any_empty;
    logic              w_fresh;
    t_idx              w_hit_idx;
    t_idx              w_empty_idx;
    t_idx              w_lru_idx;
    t_idx              w_sel;
    t_rank             w_sel_rank;

    // The result register can take a new beat when it is empty or draining.
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_advance   = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_out_free;

    // Only the low PAGE_BITS bits of the reference take part.
    assign w_page_wide = 32'(i_req.page_number);

    // Parallel tag compare against valid frames; at most one can match.
    always_comb begin
        for (int k = 0; k < FRAMES; k++) begin
            w_match[k] = r_frame_valid[k] && (r_frame_page[k] == r_in_page);
        end
    end

    assign w_hit       = |w_match;
    assign w_any_empty = !(&r_frame_valid);
    assign w_fresh     = !w_hit && w_any_empty;

    // A frame is the LRU candidate if its rank is strictly below every
    // lower-numbered frame and not above any higher-numbered one, so the
    // lowest index wins on equal ranks.
    always_comb begin
        for (int k = 0; k < FRAMES; k++) begin
            w_lru_vec[k] = 1'b1;
            for (int j = 0; j < FRAMES; j++) begin
                if ((j < k) && !(r_rank[k] < r_rank[j])) begin
                    w_lru_vec[k] = 1'b0;
                end
                if ((j > k) && !(r_rank[k] <= r_rank[j])) begin
                    w_lru_vec[k] = 1'b0;
                end
            end
        end
    end

    // Lowest-index encoders for the hit, the first empty frame and the victim.
    always_comb begin
        w_hit_idx   = '0;
        w_empty_idx = '0;
        w_lru_idx   = '0;
        for (int k = FRAMES - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_hit_idx = IDX_W'(k);
            end
            if (!r_frame_valid[k]) begin
                w_empty_idx = IDX_W'(k);
            end
            if (w_lru_vec[k]) begin
                w_lru_idx = IDX_W'(k);
            end
        end
    end

    always_comb begin
        priority if (w_hit) begin
            w_sel = w_hit_idx;
        end else if (w_any_empty) begin
            w_sel = w_empty_idx;
        end else begin
            w_sel = w_lru_idx;
        end
    end

    assign w_sel_rank   = r_rank[w_sel];
    assign w_evict_wide = 32'(r_frame_page[w_sel]);

    // Rank update: the touched frame becomes most recent; valid frames above
    // its old rank step down, or all valid frames when an empty one is filled.
    always_comb begin
        for (int k = 0; k < FRAMES; k++) begin
            n_rank[k] = r_rank[k];
            if (IDX_W'(k) == w_sel) begin
                n_rank[k] = RANK_TOP;
            end else if (r_frame_valid[k] && (w_fresh || (r_rank[k] > w_sel_rank))
                         && (r_rank[k] != '0)) begin
                n_rank[k] = r_rank[k] - RANK_W'(1);
            end
            n_frame_valid[k] = r_frame_valid[k] || (IDX_W'(k) == w_sel);
        end
    end

    assign n_tally = (!w_hit && (r_tally != TALLY_MAX)) ? r_tally + TALLY_W'(1) : r_tally;

    always_comb begin
        n_out.hit           = w_hit;
        n_out.frame_index   = FRAME_IDX_W'(w_sel);
        n_out.evicted_valid = !w_hit && !w_any_empty;
        n_out.evicted_page  = n_out.evicted_valid ? w_evict_wide[PAGE_IN_W-1:0] : '0;
        n_out.faults_so_far = n_tally;
    end

    // Control state and frame bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_frame_valid <= '0;
            r_tally       <= '0;
            for (int k = 0; k < FRAMES; k++) begin
                r_rank[k] <= '0;
            end
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_advance) begin
                r_frame_valid <= n_frame_valid;
                r_tally       <= n_tally;
                for (int k = 0; k < FRAMES; k++) begin
                    r_rank[k] <= n_rank[k];
                end
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_page <= w_page_wide[PAGE_BITS-1:0];
        end
        if (w_advance) begin
            r_out <= n_out;
            if (!w_hit) begin
                r_frame_page[w_sel] <= r_in_page;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out.hit;
    assign o_rsp.frame_index   = r_out.frame_index;
    assign o_rsp.evicted_valid = r_out.evicted_valid;
    assign o_rsp.evicted_page  = r_out.evicted_page;
    assign o_rsp.faults_so_far = r_out.faults_so_far;

endmodule

`default_nettype wire

// File: rtl/lpfr_checker.sv
// ----------------------------------------------------------------------------
// LRU page frame replacer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_page_frame_replacer_defines.svh"

module lpfr_checker import lpfr_pkg::*; #(
    parameter int FRAMES = 4
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_rsp_valid,
    input wire logic       i_rsp_ready,
    input wire logic       i_rsp_hit,
    input wire t_frame_idx i_rsp_frame_index,
    input wire logic       i_rsp_evicted_valid,
    input wire t_page      i_rsp_evicted_page,
    input wire t_tally     i_rsp_faults_so_far
);

    // A hit never replaces anything.
    `LPFR_ASSERT_IMPL(a_hit_no_evict, i_clk, i_rst_n, i_rsp_valid && i_rsp_hit, !i_rsp_evicted_valid, "eviction reported on a hit")

    // Without an eviction the evicted page reads as zero.
    `LPFR_ASSERT_IMPL(a_evict_page_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp_evicted_valid, i_rsp_evicted_page == '0, "evicted page not zero without eviction")

    // A page can only be resident after at least one fault brought it in.
    `LPFR_ASSERT_IMPL(a_hit_after_fault, i_clk, i_rst_n, i_rsp_valid && i_rsp_hit, i_rsp_faults_so_far != '0, "hit reported with zero faults")

    // The frame used always exists.
    `LPFR_ASSERT_IMPL(a_frame_in_range, i_clk, i_rst_n, i_rsp_valid, i_rsp_frame_index < FRAMES, "frame index out of range")

    // A stalled result beat holds.
    `LPFR_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_hit) && $stable(i_rsp_frame_index) && $stable(i_rsp_evicted_valid) && $stable(i_rsp_evicted_page) && $stable(i_rsp_faults_so_far), "stalled result beat changed")

endmodule

bind lru_page_frame_replacer lpfr_checker #(
    .FRAMES(FRAMES)
) u_lpfr_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_hit           (o_rsp.hit),
    .i_rsp_frame_index   (o_rsp.frame_index),
    .i_rsp_evicted_valid (o_rsp.evicted_valid),
    .i_rsp_evicted_page  (o_rsp.evicted_page),
    .i_rsp_faults_so_far (o_rsp.faults_so_far)
);

`default_nettype wire
